// File: src/pop_best_candidate_table_unit_macros.svh
// Assertion macros for the candidate table unit.
`ifndef POP_BEST_CANDIDATE_TABLE_UNIT_MACROS_SVH
`define POP_BEST_CANDIDATE_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define PBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBC_ASSERT(label, clk, rst, prop, msg)
`define PBC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: src/pbct_pkg.sv
// ----------------------------------------------------------------------------
// pbct_pkg
// Types and constants shared by the candidate table controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pbct_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  localparam logic [0:0] REG_PREFER_LARGEST = 1'b0;
  localparam logic [0:0] REG_SCAN_LENGTH    = 1'b1;

  localparam logic signed [31:0] EMPTY_ID = -32'sd1;

  typedef struct packed {
    logic               command;
    logic [5:0]         slot;
    logic signed [31:0] entry_id;
    logic [31:0]        entry_score;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_id;
    logic [31:0]        popped_score;
    logic               found;
    logic [6:0]         valid_remaining;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_TAKE,
    ST_DONE
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_write;
    logic scan_start;
    logic scan_step;
    logic take_best;
    logic make_result;
  } dp_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic is_pop;
    logic scan_last;
  } dp_status_t;

  // True when a is a better score than b under the preference, ties taken.
  function automatic logic score_takes(input logic [31:0] a, input logic [31:0] b,
                                       input logic largest);
    logic a_zero, b_zero, a_lt_b, eq;
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    eq = (a == b) || (a_zero && b_zero);
    if (a[31] != b[31]) a_lt_b = a[31];
    else if (a[31])     a_lt_b = a[30:0] > b[30:0];
    else                a_lt_b = a[30:0] < b[30:0];
    if (eq) score_takes = 1'b1;
    else if (largest) score_takes = !a_lt_b;
    else score_takes = a_lt_b;
  endfunction

  function automatic logic score_nan(input logic [31:0] s);
    score_nan = (s[30:23] == 8'hFF) && (s[22:0] != 23'd0);
  endfunction

endpackage

// File: src/pbct_ctrl.sv
// ----------------------------------------------------------------------------
// pbct_ctrl
// Sequencer: accepts one item, runs a write or a slot scan, offers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pop_best_candidate_table_unit_macros.svh"
module pbct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                cfg_ready,
  output pbct_pkg::dp_cmd_t   cmd,
  input  pbct_pkg::dp_status_t status
);
  import pbct_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DONE;
      ST_DONE:  begin
        // Decide the work of the freshly loaded item.
        state_next = status.is_pop ? ST_SCAN : ST_WRITE;
      end
      ST_WRITE: state_next = ST_TAKE;
      ST_SCAN:  if (status.scan_last) state_next = ST_TAKE;
      ST_TAKE:  if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs. ST_DONE doubles as the decode state; ST_TAKE offers the result.
  always_comb begin
    cmd       = '0;
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_TAKE);
    cfg_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE:  cmd.load_item = in_valid;
      ST_DONE:  begin
        cmd.scan_start = status.is_pop;
      end
      ST_WRITE: begin
        cmd.do_write    = 1'b1;
        cmd.make_result = 1'b1;
      end
      ST_SCAN:  begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          cmd.take_best   = 1'b1;
          cmd.make_result = 1'b1;
        end
      end
      default: ;
    endcase
  end

  `PBC_ASSERT(a_out_only_take, clk, rst, out_valid |-> state == ST_TAKE, "out_valid outside take")
  `PBC_ASSERT(a_hold_result, clk, rst, out_valid && out_stall |=> out_valid, "result dropped")
  `PBC_ASSERT(a_no_accept_busy, clk, rst, !cfg_ready |-> in_stall, "accept while busy")
endmodule

// File: src/pbct_datapath.sv
// ----------------------------------------------------------------------------
// pbct_datapath
// Slot memories, valid bits, count, config registers and the scan comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pop_best_candidate_table_unit_macros.svh"
module pbct_datapath #(
  parameter int SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbct_pkg::in_item_t   in_item,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  input  pbct_pkg::dp_cmd_t    cmd,
  output pbct_pkg::dp_status_t status,
  output pbct_pkg::out_item_t  out_item
);
  import pbct_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic signed [31:0] ids [SLOTS];
  logic [31:0]        scores [SLOTS];
  logic [SLOTS-1:0]   valid;
  logic [6:0]         count;
  logic               prefer_largest;
  logic [6:0]         scan_length;
  in_item_t           item;
  logic [IW:0]        idx;
  logic [IW:0]        scan_end;
  logic               have;
  logic [IW-1:0]      best;
  logic signed [31:0] best_id;
  logic [31:0]        best_score;
  logic signed [31:0] rd_id;
  logic [31:0]        rd_score;
  logic               rd_ok;
  logic               slot_ok;
  logic [IW-1:0]      wslot;
  logic               take;
  logic               win;
  logic [IW-1:0]      win_idx;
  logic signed [31:0] win_id;
  logic [31:0]        win_score;

  // Scan limit is scan_length clamped to SLOTS.
  always_comb begin
    if ({25'd0, scan_length} > SLOTS) scan_end = (IW+1)'(SLOTS);
    else                             scan_end = (IW+1)'(scan_length);
  end

  assign slot_ok = ({26'd0, item.slot} < SLOTS);
  assign wslot   = IW'(item.slot);
  assign status.is_pop    = (item.command == CMD_POP);
  assign status.scan_last = (idx >= scan_end);

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefer_largest <= 1'b0;
      scan_length    <= 7'd64;
    end else if (cfg_write) begin
      if (cfg_index == REG_PREFER_LARGEST) prefer_largest <= cfg_data[0];
      else                                 scan_length    <= cfg_data[6:0];
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
  end

  // Memories: one write port, one registered read port driven by the scan index.
  always_ff @(posedge clk) begin
    if (cmd.do_write && slot_ok) begin
      ids[wslot]    <= item.entry_id;
      scores[wslot] <= item.entry_score;
    end
    rd_id    <= ids[IW'(idx)];
    rd_score <= scores[IW'(idx)];
  end

  // Candidate test on the registered read, which holds the slot of the previous idx.
  assign take = rd_ok && !score_nan(rd_score) &&
                (!have || score_takes(rd_score, best_score, prefer_largest));

  // On the last scan step the final candidate may be in flight, so the
  // winner is resolved from have/take here.
  assign win       = have || take;
  assign win_idx   = take ? IW'(idx - 1'b1) : best;
  assign win_id    = take ? rd_id : best_id;
  assign win_score = take ? rd_score : best_score;

  // Scan index, best tracking, valid bits and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= 7'd0;
      have  <= 1'b0;
      idx   <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= 1'b0;
      if (cmd.scan_start) begin
        idx  <= '0;
        have <= 1'b0;
      end
      if (cmd.scan_step || cmd.scan_start) begin
        if (!status.scan_last || cmd.scan_start) begin
          rd_ok <= !cmd.scan_start && valid[IW'(idx)] && (idx < scan_end);
          idx   <= cmd.scan_start ? '0 : idx + 1'b1;
        end
        if (take) begin
          have       <= 1'b1;
          best       <= IW'(idx - 1'b1);
          best_id    <= rd_id;
          best_score <= rd_score;
        end
      end
      if (cmd.do_write && slot_ok) begin
        valid[wslot] <= !item.entry_id[31];
        if (!valid[wslot] && !item.entry_id[31] && count != 7'd127) count <= count + 1'b1;
        else if (valid[wslot] && item.entry_id[31] && count != 7'd0) count <= count - 1'b1;
      end
      // Empty the popped slot.
      if (cmd.take_best && win) begin
        valid[win_idx] <= 1'b0;
        if (count != 7'd0) count <= count - 1'b1;
      end
    end
  end

  // Result formation.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item <= '0;
    end else if (cmd.make_result) begin
      if (cmd.do_write) begin
        out_item.popped_id    <= EMPTY_ID;
        out_item.popped_score <= '0;
        out_item.found        <= 1'b0;
        if (slot_ok && !valid[wslot] && !item.entry_id[31] && count != 7'd127)
          out_item.valid_remaining <= count + 1'b1;
        else if (slot_ok && valid[wslot] && item.entry_id[31] && count != 7'd0)
          out_item.valid_remaining <= count - 1'b1;
        else
          out_item.valid_remaining <= count;
      end else if (win) begin
        out_item.popped_id       <= win_id;
        out_item.popped_score    <= win_score;
        out_item.found           <= 1'b1;
        out_item.valid_remaining <= (count != 7'd0) ? count - 1'b1 : count;
      end else begin
        out_item.popped_id       <= EMPTY_ID;
        out_item.popped_score    <= '0;
        out_item.found           <= 1'b0;
        out_item.valid_remaining <= count;
      end
    end
  end

  `PBC_ASSERT(a_take_in_scan, clk, rst, cmd.take_best |-> cmd.scan_step, "take outside scan")
  `PBC_ASSERT(a_one_op, clk, rst, !(cmd.do_write && cmd.scan_step), "write during scan")
  `PBC_ASSERT(a_count_range, clk, rst, $countones(valid) <= SLOTS, "valid range")
endmodule

// File: src/pop_best_candidate_table_unit.sv
// ----------------------------------------------------------------------------
// pop_best_candidate_table_unit
// Candidate table with slot writes and a pop of the best scoring entry.
//
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    in_item_t
// out      output     valid / stall    out_item_t
// cfg      input      valid / ready    register index and data
//
// A write result is offered after the decode and write states; a pop result
// after the decode state and a scan of min(scan_length, SLOTS) slots: one
// comparator steps through the slot memory one slot per cycle. The next item
// is taken in the cycle after the result transfers.
// Reset clears every valid bit at once, so the table is empty right after
// reset. A stalled result holds the unit; no new item is taken until the
// result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pop_best_candidate_table_unit #(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbct_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbct_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import pbct_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pbct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cfg_ready(cfg_ready),
    .cmd(cmd), .status(status)
  );

  pbct_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data),
    .cfg_write(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .status(status), .out_item(out_data)
  );
endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Candidate table testbench
// Drives slot writes and pops into the candidate table unit, predicts each
// result from a private copy of the table, and compares every output transfer
// field by field. Covers both score preferences and several scan lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import pbct_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DIRECTED_ROWS = 20;
  localparam int HOLD_LENGTH = 400;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [31:0] cfg_data;

  pop_best_candidate_table_unit #(.SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: a shadow of the table and its registers.
  logic signed [31:0] shadow_ids [SLOTS];
  logic [31:0]        shadow_scores [SLOTS];
  logic [6:0]         shadow_count;
  logic               shadow_largest;
  logic [6:0]         shadow_scan;

  out_item_t expected_pops [$];
  int mismatches = 0;
  int directed_errors;
  int cycles = 0;
  int items_sent;
  int results_seen = 0;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_active = 1'b0;
  event hold_go;

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } table_row_t;
  table_row_t directed [DIRECTED_ROWS];

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Long receiver hold, counted in cycles once triggered.
  initial begin
    forever begin
      @(hold_go);
      hold_active = 1'b1;
      repeat (HOLD_LENGTH) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Signed-magnitude ordering of float32 patterns with both zeros equal.
  function automatic logic better_or_equal(logic [31:0] a, logic [31:0] b, logic largest);
    logic a_less;
    logic same;
    same = (a == b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0);
    if (a[31] != b[31]) a_less = a[31];
    else if (a[31]) a_less = a[30:0] > b[30:0];
    else a_less = a[30:0] < b[30:0];
    if (same) return 1'b1;
    return largest ? !a_less : a_less;
  endfunction

  function automatic logic is_nan(logic [31:0] s);
    return (s[30:23] == 8'hFF) && (s[22:0] != 23'd0);
  endfunction

  // Apply one item to the shadow table and return the expected result.
  function automatic out_item_t predict_table(in_item_t it);
    out_item_t r;
    int n;
    int best;
    logic was, now;
    r.popped_id = EMPTY_ID;
    r.popped_score = '0;
    r.found = 1'b0;
    if (it.command == CMD_WRITE) begin
      was = !shadow_ids[it.slot][31];
      now = !it.entry_id[31];
      shadow_ids[it.slot] = it.entry_id;
      shadow_scores[it.slot] = it.entry_score;
      if (!was && now && shadow_count < 7'd127) shadow_count++;
      else if (was && !now && shadow_count > 0) shadow_count--;
    end else begin
      n = (shadow_scan > SLOTS) ? SLOTS : shadow_scan;
      best = -1;
      for (int i = 0; i < n; i++) begin
        if (!shadow_ids[i][31] && !is_nan(shadow_scores[i])) begin
          if (best < 0 || better_or_equal(shadow_scores[i], shadow_scores[best],
                                          shadow_largest)) best = i;
        end
      end
      if (best >= 0) begin
        r.popped_id = shadow_ids[best];
        r.popped_score = shadow_scores[best];
        r.found = 1'b1;
        shadow_ids[best] = EMPTY_ID;
        if (shadow_count > 0) shadow_count--;
      end
    end
    r.valid_remaining = shadow_count;
    return r;
  endfunction

  // Random score: mostly a few small values so ties and zeros occur often.
  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {1'($urandom_range(0, 1)), 31'd0};
      2: return {1'b0, 8'hFF, 9'($urandom_range(1, 8)), 14'd0};
      3: return {1'($urandom_range(0, 1)), 8'h7F, 21'd0, 2'($urandom_range(0, 3))};
      default: return {1'($urandom_range(0, 1)), 8'h80, 19'd0, 4'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic in_item_t pick_item(int pop_pct);
    in_item_t it;
    it.command = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_WRITE;
    it.slot = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 7))
      0: it.entry_id = EMPTY_ID;
      1: it.entry_id = {1'b1, 31'($urandom())};
      default: it.entry_id = {1'b0, 31'($urandom())};
    endcase
    it.entry_score = pick_score();
    return it;
  endfunction

  // Output checking and receiver stalls.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_pops.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer %p", out_data);
        end else begin
          exp_r = expected_pops.pop_front();
          if (out_data.popped_id !== exp_r.popped_id ||
              out_data.popped_score !== exp_r.popped_score ||
              out_data.found !== exp_r.found ||
              out_data.valid_remaining !== exp_r.valid_remaining) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data);
          end
        end
      end
      if (hold_active) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Offer one item and wait for its transfer. Valid stays high after the
  // transfer; an idle gap drops it here, and the caller drops it before other pauses.
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_pops.push_back(predict_table(it));
    items_sent++;
  endtask

  // Wait for the table to drain, then write a register.
  task automatic write_reg(logic idx, logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PREFER_LARGEST) shadow_largest = value[0];
    else shadow_scan = value[6:0];
  endtask

  task automatic random_phase(int count, int idle_pct, int stall_pct, int pop_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) send_item(pick_item(pop_pct));
  endtask

  task automatic fill_directed();
    in_item_t it;
    out_item_t r;
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      directed[k].known = 1'b0;
      directed[k].result = '0;
    end
    // Pop on an empty table.
    it = '{command: CMD_POP, slot: 6'd0, entry_id: 32'sd0, entry_score: 32'd0};
    r = '{popped_id: EMPTY_ID, popped_score: 32'd0, found: 1'b0, valid_remaining: 7'd0};
    directed[0] = '{it, 1'b1, r};
    // Write slot 63 with the largest id and the most negative finite score.
    it = '{command: CMD_WRITE, slot: 6'd63, entry_id: 32'sh7FFFFFFF,
           entry_score: 32'hFF7FFFFF};
    r = '{popped_id: EMPTY_ID, popped_score: 32'd0, found: 1'b0, valid_remaining: 7'd1};
    directed[1] = '{it, 1'b1, r};
    // Slot 0 with id zero and a negative zero score.
    directed[2].item = '{CMD_WRITE, 6'd0, 32'sd0, 32'h80000000};
    // Positive zero in slot 5 ties with slot 0; the higher slot wins.
    directed[3].item = '{CMD_WRITE, 6'd5, 32'sd5, 32'h00000000};
    directed[4].item = '{CMD_WRITE, 6'd7, 32'sd7, 32'h7FC00000};
    directed[5].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    directed[6].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    directed[7].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    // An id other than minus one that is still negative empties a slot.
    directed[8].item = '{CMD_WRITE, 6'd10, 32'sd10, 32'h3F800000};
    directed[9].item = '{CMD_WRITE, 6'd10, 32'sh80000000, 32'hFFFFFFFF};
    directed[10].item = '{CMD_WRITE, 6'd10, 32'sh80000000, 32'h00000000};
    directed[11].item = '{CMD_WRITE, 6'd20, 32'sd20, 32'hBF800000};
    directed[12].item = '{CMD_WRITE, 6'd21, 32'sd21, 32'h7F800000};
    directed[13].item = '{CMD_WRITE, 6'd22, 32'sd22, 32'hFF800000};
    directed[14].item = '{CMD_WRITE, 6'd22, 32'sd23, 32'h00000001};
    directed[15].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    directed[16].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    directed[17].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    // Only the NaN slot is left, and it never wins.
    directed[18].item = '{CMD_POP, 6'd0, 32'sd0, 32'd0};
    // Empty the NaN slot so the table ends the walk empty.
    directed[19].item = '{CMD_WRITE, 6'd7, EMPTY_ID, 32'd0};
  endtask

  // Walk the directed table; known rows are also checked against the predictor.
  task automatic run_directed();
    out_item_t r;
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      send_item(directed[k].item);
      r = expected_pops[$];
      if (directed[k].known && r !== directed[k].result) begin
        directed_errors++;
        $display("directed row %0d: typed %p, predicted %p", k, directed[k].result, r);
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PREFER_LARGEST;
    cfg_data = '0;
    directed_errors = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_ids[i] = EMPTY_ID;
      shadow_scores[i] = '0;
    end
    shadow_count = '0;
    shadow_largest = 1'b0;
    shadow_scan = 7'd64;
    fill_directed();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    write_reg(REG_PREFER_LARGEST, 32'd1);
    run_directed();

    // Random phases across preferences, scan lengths and idling.
    write_reg(REG_PREFER_LARGEST, 32'd0);
    write_reg(REG_SCAN_LENGTH, 32'd64);
    random_phase(300, 0, 0, 40);
    write_reg(REG_SCAN_LENGTH, 32'd1);
    random_phase(150, 79, 0, 45);
    write_reg(REG_PREFER_LARGEST, 32'd1);
    write_reg(REG_SCAN_LENGTH, 32'd127);
    random_phase(300, 0, 79, 40);
    write_reg(REG_SCAN_LENGTH, 32'd0);
    random_phase(100, 28, 28, 50);
    write_reg(REG_SCAN_LENGTH, 32'd33);
    random_phase(250, 28, 28, 40);

    // Long receiver hold while items keep coming, then a full drain.
    -> hold_go;
    random_phase(50, 0, 0, 50);
    in_valid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    write_reg(REG_PREFER_LARGEST, 32'd0);
    write_reg(REG_SCAN_LENGTH, 32'd64);
    random_phase(460, 0, 0, 45);

    in_valid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items, checked %0d results over both preferences", items_sent,
             results_seen);
    $display("and scan lengths 0, 1, 33, 64 and 127, with stalls and idle gaps.");
    if (mismatches == 0 && directed_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/pbct_pkg.sv
src/pbct_ctrl.sv
src/pbct_datapath.sv
src/pop_best_candidate_table_unit.sv
dv/testbench.sv
